FILE: rtl/jnorm_pkg.sv
// shared constants, types and codes for the joystick axis normalizer
// no dependencies; every other file of the block depends on this package

package jnorm_pkg;

	localparam int ADC_BITS = 8;
	localparam int PCT_W    = 8;
	localparam int DZ_W     = 7;
	localparam int DIR_W    = 3;
	localparam int PCT_FULL = 100;

	// quotient never exceeds PCT_FULL, so seven bits cover it
	localparam int Q_BITS = 7;
	localparam int NUM_W  = ADC_BITS + Q_BITS;
	localparam int DSH_W  = ADC_BITS + Q_BITS - 1;
	localparam int CNT_W  = $clog2(Q_BITS);

	localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(10);

	localparam logic OP_CAL    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	localparam logic [DIR_W-1:0] DIR_NEUTRAL = DIR_W'(0);
	localparam logic [DIR_W-1:0] DIR_LEFT    = DIR_W'(1);
	localparam logic [DIR_W-1:0] DIR_RIGHT   = DIR_W'(2);
	localparam logic [DIR_W-1:0] DIR_UP      = DIR_W'(3);
	localparam logic [DIR_W-1:0] DIR_DOWN    = DIR_W'(4);

	typedef struct packed {
		logic cal;
		logic smp;
		logic load;
		logic step;
		logic store;
		logic out_load;
		logic axis;
	} jnorm_cmd_t;

endpackage

FILE: rtl/jnorm_if.sv
// valid/ready channel interfaces for sample, result and configuration beats
// depends on jnorm_pkg for field widths

interface jnorm_in_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [jnorm_pkg::ADC_BITS-1:0]    raw_x;
	logic [jnorm_pkg::ADC_BITS-1:0]    raw_y;
	modport source (output valid, operation, raw_x, raw_y, input ready);
	modport sink (input valid, operation, raw_x, raw_y, output ready);
endinterface

interface jnorm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [jnorm_pkg::PCT_W-1:0] pos_x;
	logic signed [jnorm_pkg::PCT_W-1:0] pos_y;
	logic [jnorm_pkg::DIR_W-1:0]       direction;
	modport source (output valid, pos_x, pos_y, direction, input ready);
	modport sink (input valid, pos_x, pos_y, direction, output ready);
endinterface

interface jnorm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [jnorm_pkg::DZ_W-1:0]        deadzone;
	modport source (output valid, deadzone, input ready);
	modport sink (input valid, deadzone, output ready);
endinterface

FILE: rtl/joystick_axis_normalizer.sv
// a sample beat yields one result beat; a calibrate beat yields none
// one divider does 7 restoring steps per axis; input waits until a sample's result is loaded
// calibrate beats apply when taken; the result register frees the input while a result waits
// reset: arst_n clears centers and bounds to zero and deadzone to 10, no result pending
// top level: joins controller and datapath; depends on jnorm_pkg and jnorm_if

module joystick_axis_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	jnorm_in_if.sink    sample,
	jnorm_out_if.source result,
	jnorm_cfg_if.sink   cfg
);
	import jnorm_pkg::*;

	jnorm_cmd_t cmd;

	assign cfg.ready = 1'b1;

	jnorm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_op     (sample.operation),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	jnorm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.raw_x        (sample.raw_x),
		.raw_y        (sample.raw_y),
		.cfg_we       (cfg.valid),
		.cfg_deadzone (cfg.deadzone),
		.pos_x        (result.pos_x),
		.pos_y        (result.pos_y),
		.direction    (result.direction)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pos_x <= 8'sd100 && result.pos_x >= -8'sd100 &&
			result.pos_y <= 8'sd100 && result.pos_y >= -8'sd100))
		else $error("result position out of range");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.direction <= DIR_DOWN))
		else $error("direction code out of range");

	a_left_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.direction == DIR_LEFT) |-> result.pos_x[PCT_W-1])
		else $error("left reported with non-negative x");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && sample.operation == OP_SAMPLE) |=> !sample.ready)
		else $error("new beat taken while a sample is in work");

endmodule

FILE: rtl/jnorm_ctrl.sv
// controller: sequences calibrate, bound update, two divisions and result hand-off
// depends on jnorm_pkg for the command struct and step count

module jnorm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	output jnorm_pkg::jnorm_cmd_t cmd
);
	import jnorm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_STORE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             axis_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.cal      = accept & (in_op == OP_CAL);
		cmd.smp      = accept & (in_op == OP_SAMPLE);
		cmd.load     = (state_q == S_LOAD);
		cmd.step     = (state_q == S_DIV);
		cmd.store    = (state_q == S_STORE);
		cmd.out_load = (state_q == S_DONE) & out_free;
		cmd.axis     = axis_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= AXIS_X;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.smp) begin
						state_q <= S_LOAD;
						axis_q  <= AXIS_X;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(Q_BITS - 1)) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (axis_q == AXIS_X) begin
						axis_q  <= AXIS_Y;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/jnorm_dp.sv
// datapath: calibration state, bounds, shared restoring divider, direction pick
// depends on jnorm_pkg; driven by commands from jnorm_ctrl

module jnorm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jnorm_pkg::jnorm_cmd_t              cmd,
	input  logic [jnorm_pkg::ADC_BITS-1:0]     raw_x,
	input  logic [jnorm_pkg::ADC_BITS-1:0]     raw_y,
	input  logic                               cfg_we,
	input  logic [jnorm_pkg::DZ_W-1:0]         cfg_deadzone,
	output logic signed [jnorm_pkg::PCT_W-1:0] pos_x,
	output logic signed [jnorm_pkg::PCT_W-1:0] pos_y,
	output logic [jnorm_pkg::DIR_W-1:0]        direction
);
	import jnorm_pkg::*;

	logic [ADC_BITS-1:0] center_x_q, center_y_q;
	logic [ADC_BITS-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
	logic [DZ_W-1:0]     dz_q;
	logic [ADC_BITS-1:0] rx_q, ry_q;

	logic [NUM_W-1:0]    rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [Q_BITS-1:0]   q_q;
	logic                neg_q;
	logic                zero_q;

	logic signed [PCT_W-1:0] pos_x_q, pos_y_q;
	logic signed [PCT_W-1:0] out_x_q, out_y_q;
	logic [DIR_W-1:0]        out_dir_q;

	// axis operands for the division setup
	logic [ADC_BITS-1:0] r, c, l, h;
	logic                hi_side;
	logic [ADC_BITS-1:0] offs, span;
	logic                span_zero;
	logic [NUM_W-1:0]    num;

	logic                ge;
	logic [Q_BITS-1:0]   qc;
	logic [PCT_W-1:0]    mag;
	logic signed [PCT_W-1:0] res;

	logic signed [PCT_W:0] px9, py9, dz9;
	logic [DIR_W-1:0]      dir;

	always_comb begin
		if (cmd.axis == AXIS_X) begin
			r = rx_q;
			c = center_x_q;
			l = low_x_q;
			h = high_x_q;
		end else begin
			r = ry_q;
			c = center_y_q;
			l = low_y_q;
			h = high_y_q;
		end
		hi_side   = (r >= c);
		offs      = hi_side ? (r - c) : (c - r);
		span      = hi_side ? (h - c) : (c - l);
		span_zero = hi_side ? (h <= c) : (l >= c);
		num       = NUM_W'(offs) * NUM_W'(PCT_FULL);
	end

	assign ge = (rem_q >= NUM_W'(dsh_q));

	always_comb begin
		qc  = (q_q > Q_BITS'(PCT_FULL)) ? Q_BITS'(PCT_FULL) : q_q;
		mag = PCT_W'(qc);
		if (zero_q) begin
			res = '0;
		end else if (neg_q) begin
			res = -signed'(mag);
		end else begin
			res = signed'(mag);
		end
	end

	// x is checked before y
	always_comb begin
		px9 = {pos_x_q[PCT_W-1], pos_x_q};
		py9 = {pos_y_q[PCT_W-1], pos_y_q};
		dz9 = signed'({2'b00, dz_q});
		priority if (px9 < -dz9) begin
			dir = DIR_LEFT;
		end else if (px9 > dz9) begin
			dir = DIR_RIGHT;
		end else if (py9 > dz9) begin
			dir = DIR_UP;
		end else if (py9 < -dz9) begin
			dir = DIR_DOWN;
		end else begin
			dir = DIR_NEUTRAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
		end else if (cfg_we) begin
			dz_q <= cfg_deadzone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			low_x_q    <= '0;
			high_x_q   <= '0;
			low_y_q    <= '0;
			high_y_q   <= '0;
		end else if (cmd.cal) begin
			center_x_q <= raw_x;
			center_y_q <= raw_y;
			low_x_q    <= raw_x;
			high_x_q   <= raw_x;
			low_y_q    <= raw_y;
			high_y_q   <= raw_y;
		end else if (cmd.smp) begin
			if (raw_x < low_x_q) begin
				low_x_q <= raw_x;
			end
			if (raw_x > high_x_q) begin
				high_x_q <= raw_x;
			end
			if (raw_y < low_y_q) begin
				low_y_q <= raw_y;
			end
			if (raw_y > high_y_q) begin
				high_y_q <= raw_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.smp) begin
			rx_q <= raw_x;
			ry_q <= raw_y;
		end
		if (cmd.load) begin
			rem_q  <= num;
			dsh_q  <= DSH_W'(span) << (Q_BITS - 1);
			q_q    <= '0;
			neg_q  <= ~hi_side;
			zero_q <= span_zero;
		end else if (cmd.step) begin
			if (ge) begin
				rem_q <= rem_q - NUM_W'(dsh_q);
			end
			q_q   <= {q_q[Q_BITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.store) begin
			if (cmd.axis == AXIS_X) begin
				pos_x_q <= res;
			end else begin
				pos_y_q <= res;
			end
		end
		if (cmd.out_load) begin
			out_x_q   <= pos_x_q;
			out_y_q   <= pos_y_q;
			out_dir_q <= dir;
		end
	end

	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign direction = out_dir_q;

endmodule

FILE: test/joystick_axis_normalizer_test.sv
// self-checking testbench for joystick_axis_normalizer: a directed table, then random
// calibrate/sample sessions under several deadzones; depends on jnorm_pkg, jnorm_if, rtl top

module joystick_axis_normalizer_test;
	import jnorm_pkg::*;

	localparam int SETTLE_CYCLES  = 30;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 215;
	localparam int NUM_PHASES     = 6;
	localparam int NUM_ROWS       = 27;
	localparam int ADC_MAX        = 2 ** ADC_BITS - 1;

	typedef struct packed {
		logic signed [PCT_W-1:0] pos_x;
		logic signed [PCT_W-1:0] pos_y;
		logic [DIR_W-1:0]        direction;
	} position_t;

	// a table row may carry its position typed in; otherwise the predictor supplies it
	typedef struct packed {
		logic      listed;
		position_t pos;
	} answer_t;

	typedef enum logic [1:0] {ROW_CAL, ROW_SAMPLE, ROW_DZ} row_kind_e;

	typedef struct packed {
		row_kind_e           kind;
		logic [ADC_BITS-1:0] x;
		logic [ADC_BITS-1:0] y;
		logic                listed;
		position_t           want;
	} row_t;

	// for deadzone rows the x column holds the new deadzone
	row_t stim_table [NUM_ROWS] = '{
		'{ROW_SAMPLE, 8'd0,   8'd0,   1'b1, '{8'sd0,    8'sd0,    DIR_NEUTRAL}},
		'{ROW_SAMPLE, 8'd255, 8'd255, 1'b1, '{8'sd100,  8'sd100,  DIR_RIGHT}},
		'{ROW_CAL,    8'd128, 8'd128, 1'b0, '0},
		'{ROW_SAMPLE, 8'd128, 8'd128, 1'b1, '{8'sd0,    8'sd0,    DIR_NEUTRAL}},
		'{ROW_SAMPLE, 8'd255, 8'd128, 1'b1, '{8'sd100,  8'sd0,    DIR_RIGHT}},
		'{ROW_SAMPLE, 8'd0,   8'd128, 1'b1, '{-8'sd100, 8'sd0,    DIR_LEFT}},
		'{ROW_SAMPLE, 8'd128, 8'd255, 1'b1, '{8'sd0,    8'sd100,  DIR_UP}},
		'{ROW_SAMPLE, 8'd128, 8'd0,   1'b1, '{8'sd0,    -8'sd100, DIR_DOWN}},
		'{ROW_SAMPLE, 8'd140, 8'd128, 1'b0, '0},
		'{ROW_SAMPLE, 8'd192, 8'd64,  1'b0, '0},
		'{ROW_SAMPLE, 8'd100, 8'd140, 1'b0, '0},
		'{ROW_CAL,    8'd0,   8'd255, 1'b0, '0},
		'{ROW_SAMPLE, 8'd0,   8'd255, 1'b1, '{8'sd0,    8'sd0,    DIR_NEUTRAL}},
		'{ROW_SAMPLE, 8'd255, 8'd0,   1'b1, '{8'sd100,  -8'sd100, DIR_RIGHT}},
		'{ROW_SAMPLE, 8'd1,   8'd254, 1'b0, '0},
		'{ROW_CAL,    8'd255, 8'd0,   1'b0, '0},
		'{ROW_SAMPLE, 8'd0,   8'd255, 1'b1, '{-8'sd100, 8'sd100,  DIR_LEFT}},
		'{ROW_SAMPLE, 8'd200, 8'd30,  1'b0, '0},
		'{ROW_CAL,    8'd85,  8'd170, 1'b0, '0},
		'{ROW_SAMPLE, 8'd170, 8'd85,  1'b0, '0},
		'{ROW_SAMPLE, 8'd86,  8'd169, 1'b0, '0},
		'{ROW_DZ,     8'd100, 8'd0,   1'b0, '0},
		'{ROW_SAMPLE, 8'd0,   8'd0,   1'b1, '{-8'sd100, -8'sd100, DIR_NEUTRAL}},
		'{ROW_DZ,     8'd127, 8'd0,   1'b0, '0},
		'{ROW_SAMPLE, 8'd255, 8'd255, 1'b1, '{8'sd100,  8'sd100,  DIR_NEUTRAL}},
		'{ROW_DZ,     8'd0,   8'd0,   1'b0, '0},
		'{ROW_SAMPLE, 8'd86,  8'd171, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	bit   idling = 1'b1;

	jnorm_in_if  sample_ch ();
	jnorm_out_if result_ch ();
	jnorm_cfg_if cfg_ch ();

	joystick_axis_normalizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predictor state, cleared like the block's reset
	logic [ADC_BITS-1:0] ctr_x = '0, ctr_y = '0;
	logic [ADC_BITS-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
	logic [DZ_W-1:0]     dz_model = DZ_RESET;

	position_t expected_positions [$];
	answer_t   listed_answers [$];

	int mismatches     = 0;
	int cal_beats      = 0;
	int sample_beats   = 0;
	int checked_beats  = 0;
	int dz_writes      = 0;
	int stalled_cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [PCT_W-1:0] percent_of_span(logic [ADC_BITS-1:0] raw, ctr, lo, hi);
		int v;
		if (raw >= ctr) begin
			if (hi <= ctr)
				return '0;
			v = (int'(raw) - int'(ctr)) * PCT_FULL / (int'(hi) - int'(ctr));
		end else begin
			if (lo >= ctr)
				return '0;
			v = -((int'(ctr) - int'(raw)) * PCT_FULL / (int'(ctr) - int'(lo)));
		end
		if (v > PCT_FULL)
			v = PCT_FULL;
		if (v < -PCT_FULL)
			v = -PCT_FULL;
		return PCT_W'(v);
	endfunction

	// widens the bounds, then normalizes both axes and picks the direction, x first
	function automatic position_t predict_position(logic [ADC_BITS-1:0] x, y);
		position_t p;
		int        px, py, dz;
		if (x < lo_x) lo_x = x;
		if (x > hi_x) hi_x = x;
		if (y < lo_y) lo_y = y;
		if (y > hi_y) hi_y = y;
		p.pos_x = percent_of_span(x, ctr_x, lo_x, hi_x);
		p.pos_y = percent_of_span(y, ctr_y, lo_y, hi_y);
		px = $signed(p.pos_x);
		py = $signed(p.pos_y);
		dz = int'(dz_model);
		if (px < -dz)
			p.direction = DIR_LEFT;
		else if (px > dz)
			p.direction = DIR_RIGHT;
		else if (py > dz)
			p.direction = DIR_UP;
		else if (py < -dz)
			p.direction = DIR_DOWN;
		else
			p.direction = DIR_NEUTRAL;
		return p;
	endfunction

	function automatic logic [ADC_BITS-1:0] near_point(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return ADC_BITS'(v);
	endfunction

	task automatic send_beat(input logic op, input logic [ADC_BITS-1:0] x, y, input answer_t ans);
		int gap;
		gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		listed_answers.push_back(ans);
		sample_ch.valid     <= 1'b1;
		sample_ch.operation <= op;
		sample_ch.raw_x     <= x;
		sample_ch.raw_y     <= y;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
	endtask

	// deadzone changes only once the block has drained; a trailing calibrate gives no beat
	task automatic set_deadzone(input logic [DZ_W-1:0] dz);
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_positions.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.deadzone <= dz;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 6) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t   ans;
		position_t want;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				dz_model = cfg_ch.deadzone;
				dz_writes++;
				moved = 1'b1;
			end
			if (sample_ch.valid && sample_ch.ready) begin
				ans   = listed_answers.pop_front();
				moved = 1'b1;
				if (sample_ch.operation == OP_CAL) begin
					ctr_x = sample_ch.raw_x;
					lo_x  = sample_ch.raw_x;
					hi_x  = sample_ch.raw_x;
					ctr_y = sample_ch.raw_y;
					lo_y  = sample_ch.raw_y;
					hi_y  = sample_ch.raw_y;
					cal_beats++;
				end else begin
					want = predict_position(sample_ch.raw_x, sample_ch.raw_y);
					expected_positions.push_back(ans.listed ? ans.pos : want);
					sample_beats++;
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				if (expected_positions.size() == 0) begin
					$error("position beat arrived with none expected");
					mismatches++;
				end else begin
					want = expected_positions.pop_front();
					checked_beats++;
					if (result_ch.pos_x !== want.pos_x) begin
						$error("pos_x: expected %0d, actual %0d", $signed(want.pos_x),
							result_ch.pos_x);
						mismatches++;
					end
					if (result_ch.pos_y !== want.pos_y) begin
						$error("pos_y: expected %0d, actual %0d", $signed(want.pos_y),
							result_ch.pos_y);
						mismatches++;
					end
					if (result_ch.direction !== want.direction) begin
						$error("direction: expected %0d, actual %0d", want.direction,
							result_ch.direction);
						mismatches++;
					end
				end
			end
			stalled_cycles = moved ? 0 : stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("[joystick_axis_normalizer] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int                  done, n, cx, cy, k;
		logic [ADC_BITS-1:0] x, y;
		logic [DZ_W-1:0]     dz;
		arst_n              = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.operation = OP_CAL;
		sample_ch.raw_x     = '0;
		sample_ch.raw_y     = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.deadzone     = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_DZ)
				set_deadzone(DZ_W'(stim_table[i].x));
			else
				send_beat(stim_table[i].kind == ROW_CAL ? OP_CAL : OP_SAMPLE,
					stim_table[i].x, stim_table[i].y,
					'{stim_table[i].listed, stim_table[i].want});
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: dz = DZ_W'(0);
				1: dz = DZ_W'(PCT_FULL);
				2: dz = '1;
				default: dz = DZ_W'($urandom_range(0, PCT_FULL));
			endcase
			// one middle phase and the last one run without any idling
			idling = !(phase == 2 || phase == NUM_PHASES - 1);
			set_deadzone(dz);
			done = 0;
			cx   = ADC_MAX / 2;
			cy   = ADC_MAX / 2;
			while (done < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise beat, either operation, anywhere
					send_beat(1'($urandom_range(0, 1)), ADC_BITS'($urandom_range(0, ADC_MAX)),
						ADC_BITS'($urandom_range(0, ADC_MAX)), '0);
					done++;
				end else begin
					k  = $urandom_range(0, 7);
					cx = (k == 0) ? 0 : (k == 1) ? ADC_MAX : $urandom_range(0, ADC_MAX);
					k  = $urandom_range(0, 7);
					cy = (k == 0) ? 0 : (k == 1) ? ADC_MAX : $urandom_range(0, ADC_MAX);
					send_beat(OP_CAL, ADC_BITS'(cx), ADC_BITS'(cy), '0);
					done++;
					n = $urandom_range(1, 24);
					repeat (n) begin
						k = $urandom_range(0, 5);
						if (k < 2) begin
							x = ADC_BITS'($urandom_range(0, ADC_MAX));
							y = ADC_BITS'($urandom_range(0, ADC_MAX));
						end else if (k < 5) begin
							// close to center, where the deadzone decides
							x = near_point(cx, (k < 4) ? 12 : 40);
							y = near_point(cy, (k < 4) ? 12 : 40);
						end else begin
							x = $urandom_range(0, 1) ? ADC_BITS'(ADC_MAX) : '0;
							y = $urandom_range(0, 1) ? ADC_BITS'(ADC_MAX) : '0;
						end
						send_beat(OP_SAMPLE, x, y, '0);
						done++;
					end
				end
			end
		end

		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d calibrate and %0d sample beats sent, %0d positions compared",
			cal_beats, sample_beats, checked_beats);
		$display("%0d deadzone writes including 0, 100 and 127, with and without idle bursts",
			dz_writes);
		if (mismatches == 0)
			$display("[joystick_axis_normalizer] OK");
		else
			$display("[joystick_axis_normalizer] ERROR");
		$finish;
	end

endmodule

FILE: joystick_axis_normalizer.f
rtl/jnorm_pkg.sv
rtl/jnorm_if.sv
rtl/jnorm_ctrl.sv
rtl/jnorm_dp.sv
rtl/joystick_axis_normalizer.sv
test/joystick_axis_normalizer_test.sv
